// File: hdl/dlss_pkg.sv
// Shared types and constants for the dual linked stacks block.
// Used by every module in hdl/; depends on nothing.
package dlss_pkg;

   // Field widths of the request and response channels
   localparam int VALUE_W  = 32;
   localparam int FUNC_W   = 2;
   localparam int STATUS_W = 2;

   // Free map word geometry
   localparam int MAP_WORD_BITS = 32;
   localparam int MAP_BIT_W     = 5;

   // Operation codes
   localparam logic [FUNC_W-1:0] FUNC_PUSH   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_LIST   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_POP    = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   // Response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PUSH,
      ST_POP,
      ST_LIST,
      ST_REPLY
   } seq_state_type;

   // Commands from the sequencer to the free map
   typedef struct packed {
      logic find;   // read the word holding the lowest free node
      logic probe;  // read the word holding probe_node
      logic take;   // mark the found free node in use
      logic give;   // mark the probed node free
   } map_ctl_type;

endpackage

// File: hdl/dlss_free_map.sv
// Free node map: one in-use bit per pool node, kept in 32-bit words in a memory.
// Depends on dlss_pkg (map_ctl_type, map word geometry).
module dlss_free_map #(
   parameter int POOL_NODES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dlss_pkg::map_ctl_type         ctl,
   input  logic [$clog2(POOL_NODES)-1:0] probe_node,
   output logic                          pool_full,
   output logic [$clog2(POOL_NODES)-1:0] free_node
);
   import dlss_pkg::*;

   localparam int NODE_W = $clog2(POOL_NODES);
   localparam int WORDS  = (POOL_NODES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
   localparam int WORD_W = (WORDS > 1) ? $clog2(WORDS) : 1;

   logic [MAP_WORD_BITS-1:0] map_mem [WORDS];

   logic [WORDS-1:0]         has_free_ff, has_free_in;
   logic [WORDS-1:0]         written_ff, written_in;
   logic [MAP_WORD_BITS-1:0] rd_data_ff;
   logic                     rd_written_ff;
   logic [WORD_W-1:0]        rd_idx_ff, rd_idx_in;
   logic [MAP_BIT_W-1:0]     rd_bit_ff, rd_bit_in;
   logic                     rd_en, wr_en;
   logic [WORD_W-1:0]        first_word;
   logic [MAP_BIT_W-1:0]     first_bit;
   logic [MAP_WORD_BITS-1:0] cur_word, busy_word, wr_word;

   // Bits past the end of the pool always look busy
   function automatic logic [MAP_WORD_BITS-1:0] pad_mask(input logic [WORD_W-1:0] idx);
      logic [MAP_WORD_BITS-1:0] m;
      for (int b = 0; b < MAP_WORD_BITS; b++) begin
         m[b] = (int'(idx) * MAP_WORD_BITS + b) >= POOL_NODES;
      end
      return m;
   endfunction

   // Lowest word that still has a free node
   always_comb begin
      first_word = '0;
      for (int w = WORDS - 1; w >= 0; w--) begin
         if (has_free_ff[w]) begin
            first_word = WORD_W'(w);
         end
      end
   end

   assign pool_full = ~|has_free_ff;

   // A word never written reads as all free
   assign cur_word  = rd_written_ff ? rd_data_ff : '0;
   assign busy_word = cur_word | pad_mask(rd_idx_ff);

   // Lowest free bit in the word just read
   always_comb begin
      first_bit = '0;
      for (int b = MAP_WORD_BITS - 1; b >= 0; b--) begin
         if (!busy_word[b]) begin
            first_bit = MAP_BIT_W'(b);
         end
      end
   end

   assign free_node = NODE_W'({rd_idx_ff, first_bit});

   // Read address and bit select
   assign rd_en     = ctl.find | ctl.probe;
   assign rd_idx_in = ctl.find ? first_word : WORD_W'(probe_node >> MAP_BIT_W);
   assign rd_bit_in = MAP_BIT_W'(probe_node);

   // Write-back word for take and give
   always_comb begin
      wr_en       = ctl.take | ctl.give;
      wr_word     = cur_word;
      written_in  = written_ff;
      has_free_in = has_free_ff;
      if (ctl.take) begin
         wr_word = cur_word | (MAP_WORD_BITS'(1) << first_bit);
      end else if (ctl.give) begin
         wr_word = cur_word & ~(MAP_WORD_BITS'(1) << rd_bit_ff);
      end
      if (wr_en) begin
         written_in[rd_idx_ff]  = 1'b1;
         has_free_in[rd_idx_ff] = ~&(wr_word | pad_mask(rd_idx_ff));
      end
   end

   // Map memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[rd_idx_ff] <= wr_word;
      end
      if (rd_en) begin
         rd_data_ff    <= map_mem[rd_idx_in];
         rd_written_ff <= written_ff[rd_idx_in];
         rd_idx_ff     <= rd_idx_in;
         rd_bit_ff     <= rd_bit_in;
      end
   end

   // Per-word summary flags
   always_ff @(posedge clock) begin
      if (reset) begin
         has_free_ff <= '1;
         written_ff  <= '0;
      end else begin
         has_free_ff <= has_free_in;
         written_ff  <= written_in;
      end
   end

endmodule

// File: hdl/dual_linked_stacks_shared_pool.sv
// Top level: two LIFO stacks over one shared pool of linked nodes.
// Depends on dlss_pkg and dlss_free_map.
//
//   channel   direction  handshake           payload
//   req_      in         req_valid/req_stall func, which_stack, push_value
//   rsp_      out        rsp_valid/rsp_stall status, item_value, last
//
// Push reads the free map and pop reads the node and map memories, each a registered read
// followed by the write-back. A list reads one node per entry. Empty or full replies pass
// through a reply state; the unused operation code gets no response.
// Reset is synchronous and needs no clearing pass: map words carry written flags.
// req_stall is high while an item is in progress; results leave through an output
// register, so a waiting final result does not hold off the next request.
module dual_linked_stacks_shared_pool #(
   parameter int POOL_NODES = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [dlss_pkg::FUNC_W-1:0]         req_func,
   input  logic                                req_which_stack,
   input  logic signed [dlss_pkg::VALUE_W-1:0] req_push_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [dlss_pkg::STATUS_W-1:0]       rsp_status,
   output logic signed [dlss_pkg::VALUE_W-1:0] rsp_item_value,
   output logic                                rsp_last
);
   import dlss_pkg::*;

   localparam int NODE_W  = $clog2(POOL_NODES);
   localparam int LINK_W  = $clog2(POOL_NODES + 1);
   localparam int ENTRY_W = VALUE_W + LINK_W;

   // Node memory: {value, link}, link is node number plus one, zero for none
   logic [ENTRY_W-1:0] node_mem [POOL_NODES];
   logic [ENTRY_W-1:0] node_q_ff;
   logic               node_rd_en, node_wr_en;
   logic [NODE_W-1:0]  node_rd_addr, node_wr_addr;
   logic [ENTRY_W-1:0] node_wr_data;

   seq_state_type      state_ff, state_in;
   logic               sel_ff;
   logic [VALUE_W-1:0] value_ff;
   logic [STATUS_W-1:0] reply_ff, reply_in;
   logic [NODE_W-1:0]  count_ff, count_in;
   logic [LINK_W-1:0]  tops_ff [2];
   logic               top_wr_en;
   logic [LINK_W-1:0]  top_wr_val;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                rsp_load;

   map_ctl_type        map_ctl;
   logic               pool_full;
   logic [NODE_W-1:0]  free_node;

   logic               accept, out_free;
   logic [LINK_W-1:0]  req_top, top_sel, q_link;
   logic [VALUE_W-1:0] q_value;
   logic               req_empty, list_last;

   dlss_free_map #(
      .POOL_NODES (POOL_NODES)
   ) u_free_map (
      .clock      (clock),
      .reset      (reset),
      .ctl        (map_ctl),
      .probe_node (node_rd_addr),
      .pool_full  (pool_full),
      .free_node  (free_node)
   );

   // Handshake and decode helpers
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_top   = tops_ff[req_which_stack];
   assign req_empty = (req_top == '0) || (req_top > LINK_W'(POOL_NODES));
   assign top_sel   = tops_ff[sel_ff];
   assign q_value   = node_q_ff[ENTRY_W-1:LINK_W];
   assign q_link    = node_q_ff[LINK_W-1:0];
   assign list_last = (q_link == '0) || (q_link > LINK_W'(POOL_NODES))
                      || (count_ff == NODE_W'(POOL_NODES - 1));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_func)
                  FUNC_PUSH: state_in = pool_full ? ST_REPLY : ST_PUSH;
                  FUNC_POP:  state_in = req_empty ? ST_REPLY : ST_POP;
                  FUNC_LIST: state_in = req_empty ? ST_REPLY : ST_LIST;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_PUSH, ST_POP, ST_REPLY: begin
            if (out_free) state_in = ST_IDLE;
         end
         ST_LIST: begin
            if (out_free && list_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs: memory commands, top updates, response load
   always_comb begin
      map_ctl       = '0;
      node_rd_en    = 1'b0;
      node_rd_addr  = NODE_W'(req_top - LINK_W'(1));
      node_wr_en    = 1'b0;
      node_wr_addr  = free_node;
      node_wr_data  = {value_ff, top_sel};
      top_wr_en     = 1'b0;
      top_wr_val    = LINK_W'(free_node) + LINK_W'(1);
      rsp_load      = 1'b0;
      rsp_status_in = STATUS_OK;
      rsp_value_in  = '0;
      rsp_last_in   = 1'b1;
      count_in      = count_ff;
      reply_in      = reply_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               count_in = '0;
               reply_in = (req_func == FUNC_PUSH) ? STATUS_FULL : STATUS_EMPTY;
               case (req_func)
                  FUNC_PUSH: map_ctl.find = !pool_full;
                  FUNC_POP: begin
                     node_rd_en    = !req_empty;
                     map_ctl.probe = !req_empty;
                  end
                  FUNC_LIST: node_rd_en = !req_empty;
                  default: ;
               endcase
            end
         end
         ST_PUSH: begin
            if (out_free) begin
               node_wr_en   = 1'b1;
               top_wr_en    = 1'b1;
               map_ctl.take = 1'b1;
               rsp_load     = 1'b1;
            end
         end
         ST_POP: begin
            if (out_free) begin
               top_wr_en    = 1'b1;
               top_wr_val   = q_link;
               map_ctl.give = 1'b1;
               rsp_load     = 1'b1;
               rsp_value_in = q_value;
            end
         end
         ST_LIST: begin
            node_rd_addr = NODE_W'(q_link - LINK_W'(1));
            if (out_free) begin
               rsp_load     = 1'b1;
               rsp_value_in = q_value;
               rsp_last_in  = list_last;
               if (!list_last) begin
                  node_rd_en = 1'b1;
                  count_in   = count_ff + NODE_W'(1);
               end
            end
         end
         ST_REPLY: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_status_in = reply_ff;
            end
         end
         default: ;
      endcase
   end

   // Node memory, registered read
   always_ff @(posedge clock) begin
      if (node_wr_en) begin
         node_mem[node_wr_addr] <= node_wr_data;
      end
      if (node_rd_en) begin
         node_q_ff <= node_mem[node_rd_addr];
      end
   end

   // Request capture and walk counter
   always_ff @(posedge clock) begin
      if (accept) begin
         sel_ff   <= req_which_stack;
         value_ff <= req_push_value;
      end
      reply_ff <= reply_in;
      count_ff <= count_in;
   end

   // Control state and stack tops
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         tops_ff[0] <= '0;
         tops_ff[1] <= '0;
      end else begin
         state_ff <= state_in;
         if (top_wr_en) begin
            tops_ff[sel_ff] <= top_wr_val;
         end
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_value_ff  <= rsp_value_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_item_value = rsp_value_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

// File: hdl/dlss_checker.sv
// Port-level checks for dual_linked_stacks_shared_pool, attached by bind.
// Depends on dlss_pkg (codes and widths).
module dlss_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic [dlss_pkg::FUNC_W-1:0]         req_func,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [dlss_pkg::STATUS_W-1:0]       rsp_status,
   input logic signed [dlss_pkg::VALUE_W-1:0] rsp_item_value,
   input logic                                rsp_last
);
   import dlss_pkg::*;

   logic [2:0] open_ff, open_in;
   logic       req_take, rsp_done;

   // Requests that still owe their final response
   assign req_take = req_valid && !req_stall && (req_func != FUNC_UNUSED);
   assign rsp_done = rsp_valid && !rsp_stall && rsp_last;

   always_comb begin
      open_in = open_ff + 3'(req_take) - 3'(rsp_done);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   // No response without an earlier request that owes one
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> open_ff != 3'd0)
      else $error("response with no open request");

   // Error statuses are single final responses with zero value
   a_err_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_last && rsp_item_value == '0)
      else $error("error response not final or not zero");

   // Only list entries come without the final mark, and they are ok
   a_mid_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_status == STATUS_OK)
      else $error("non-final response with error status");

   // Stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
                                 && $stable(rsp_item_value) && $stable(rsp_last))
      else $error("stalled response changed");

endmodule

bind dual_linked_stacks_shared_pool dlss_checker u_dlss_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_func       (req_func),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_status     (rsp_status),
   .rsp_item_value (rsp_item_value),
   .rsp_last       (rsp_last)
);
